// File: sv/gotp_pkg.sv
// Package: token and record codes, item types and defaults for the glyph outline token parser.
package gotp_pkg;

   localparam int MAX_PATHS_DEFAULT   = 100;
   localparam int MAX_POINTS_DEFAULT  = 100;
   localparam int GLYPH_SLOTS_DEFAULT = 65536;

   localparam int KIND_W  = 4;
   localparam int CODE_W  = 16;
   localparam int COORD_W = 32;
   localparam int REC_W   = 3;
   localparam int IDX_W   = 7;

   localparam logic [KIND_W-1:0] TK_CODE    = 4'd0;
   localparam logic [KIND_W-1:0] TK_EQUALS  = 4'd1;
   localparam logic [KIND_W-1:0] TK_LBRACE  = 4'd2;
   localparam logic [KIND_W-1:0] TK_LPAR    = 4'd3;
   localparam logic [KIND_W-1:0] TK_RPAR    = 4'd4;
   localparam logic [KIND_W-1:0] TK_NUMBER  = 4'd5;
   localparam logic [KIND_W-1:0] TK_COLON   = 4'd6;
   localparam logic [KIND_W-1:0] TK_COMMA   = 4'd7;
   localparam logic [KIND_W-1:0] TK_GREATER = 4'd8;
   localparam logic [KIND_W-1:0] TK_RBRACE  = 4'd9;
   localparam logic [KIND_W-1:0] TK_END     = 4'd11;

   localparam logic [REC_W-1:0] RK_GLYPH    = 3'd0;
   localparam logic [REC_W-1:0] RK_PATH     = 3'd1;
   localparam logic [REC_W-1:0] RK_POINT    = 3'd2;
   localparam logic [REC_W-1:0] RK_ADVANCE  = 3'd3;
   localparam logic [REC_W-1:0] RK_SYNTAX   = 3'd4;
   localparam logic [REC_W-1:0] RK_OVERFLOW = 3'd5;
   localparam logic [REC_W-1:0] RK_SUCCESS  = 3'd6;

   typedef struct packed {
      logic [KIND_W-1:0]         token_kind;
      logic [CODE_W-1:0]         code_value;
      logic signed [COORD_W-1:0] number_value;
   } token_type;

   typedef struct packed {
      logic [REC_W-1:0]          record_kind;
      logic [CODE_W-1:0]         glyph_code;
      logic [IDX_W-1:0]          path_index;
      logic [IDX_W-1:0]          point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic                      bezier_control;
   } record_type;

endpackage

// File: sv/gotp_req_if.sv
// Interface: token channel with valid/ready handshake.
interface gotp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [gotp_pkg::KIND_W-1:0]           token_kind;
   logic [gotp_pkg::CODE_W-1:0]           code_value;
   logic signed [gotp_pkg::COORD_W-1:0]   number_value;

   modport source (output valid, output token_kind, output code_value, output number_value,
                   input ready);
   modport sink   (input valid, input token_kind, input code_value, input number_value,
                   output ready);
endinterface

// File: sv/gotp_rsp_if.sv
// Interface: record channel with valid/ready handshake.
interface gotp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [gotp_pkg::REC_W-1:0]            record_kind;
   logic [gotp_pkg::CODE_W-1:0]           glyph_code;
   logic [gotp_pkg::IDX_W-1:0]            path_index;
   logic [gotp_pkg::IDX_W-1:0]            point_index;
   logic signed [gotp_pkg::COORD_W-1:0]   coord_x;
   logic signed [gotp_pkg::COORD_W-1:0]   coord_y;
   logic                                  bezier_control;

   modport source (output valid, output record_kind, output glyph_code, output path_index,
                   output point_index, output coord_x, output coord_y,
                   output bezier_control, input ready);
   modport sink   (input valid, input record_kind, input glyph_code, input path_index,
                   input point_index, input coord_x, input coord_y,
                   input bezier_control, output ready);
endinterface

// File: sv/gotp_parser.sv
// Grammar state machine, counters and held values; builds at most one record per token.
module gotp_parser #(
   parameter int MAX_PATHS   = gotp_pkg::MAX_PATHS_DEFAULT,
   parameter int MAX_POINTS  = gotp_pkg::MAX_POINTS_DEFAULT,
   parameter int GLYPH_SLOTS = gotp_pkg::GLYPH_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  gotp_pkg::token_type    token,
   output logic                   rec_valid,
   output gotp_pkg::record_type   rec
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_GOT_CODE = 4'd1;
   localparam logic [3:0] S_GOT_EQ   = 4'd2;
   localparam logic [3:0] S_BODY     = 4'd3;
   localparam logic [3:0] S_IN_PATH  = 4'd4;
   localparam logic [3:0] S_PT_X     = 4'd5;
   localparam logic [3:0] S_PT_SEP   = 4'd6;
   localparam logic [3:0] S_ADV_GT   = 4'd7;
   localparam logic [3:0] S_ADV_X    = 4'd8;
   localparam logic [3:0] S_ADV_SEP  = 4'd9;
   localparam logic [3:0] S_ADV_Y    = 4'd10;

   localparam logic [gotp_pkg::IDX_W-1:0] PATH_LIMIT  = gotp_pkg::IDX_W'(MAX_PATHS);
   localparam logic [gotp_pkg::IDX_W-1:0] POINT_LIMIT = gotp_pkg::IDX_W'(MAX_POINTS);
   localparam logic [gotp_pkg::CODE_W:0]  SLOT_LIMIT  = (gotp_pkg::CODE_W+1)'(GLYPH_SLOTS);

   logic [3:0]                           state_ff, state_in;
   logic signed [gotp_pkg::COORD_W-1:0]  held_x_ff, held_x_in;
   logic                                 held_marker_ff, held_marker_in;
   logic [gotp_pkg::CODE_W-1:0]          current_code_ff, current_code_in;
   logic [gotp_pkg::IDX_W-1:0]           path_count_ff, path_count_in;
   logic [gotp_pkg::IDX_W-1:0]           point_count_ff, point_count_in;
   logic signed [gotp_pkg::COORD_W-1:0]  held_adv_x_ff, held_adv_x_in;
   logic                                 halted_ff, halted_in;
   logic                                 syn_err, ovf_err;

   always_comb begin
      state_in        = state_ff;
      held_x_in       = held_x_ff;
      held_marker_in  = held_marker_ff;
      current_code_in = current_code_ff;
      path_count_in   = path_count_ff;
      point_count_in  = point_count_ff;
      held_adv_x_in   = held_adv_x_ff;
      halted_in       = halted_ff;
      syn_err         = 1'b0;
      ovf_err         = 1'b0;
      rec_valid       = 1'b0;
      rec             = '0;
      if (step && !halted_ff) begin
         if (token.token_kind == gotp_pkg::TK_END) begin
            if (state_ff == S_IDLE) begin
               rec_valid       = 1'b1;
               rec.record_kind = gotp_pkg::RK_SUCCESS;
            end else begin
               syn_err = 1'b1;
            end
         end else begin
            unique case (state_ff)
               S_IDLE: begin
                  if (token.token_kind != gotp_pkg::TK_CODE) begin
                     syn_err = 1'b1;
                  end else if ({1'b0, token.code_value} >= SLOT_LIMIT) begin
                     ovf_err = 1'b1;
                  end else begin
                     current_code_in = token.code_value;
                     path_count_in   = '0;
                     point_count_in  = '0;
                     state_in        = S_GOT_CODE;
                     rec_valid       = 1'b1;
                     rec.record_kind = gotp_pkg::RK_GLYPH;
                     rec.glyph_code  = token.code_value;
                  end
               end
               S_GOT_CODE: begin
                  if (token.token_kind == gotp_pkg::TK_EQUALS) state_in = S_GOT_EQ;
                  else syn_err = 1'b1;
               end
               S_GOT_EQ: begin
                  if (token.token_kind == gotp_pkg::TK_LBRACE) state_in = S_BODY;
                  else syn_err = 1'b1;
               end
               S_BODY: begin
                  if (token.token_kind == gotp_pkg::TK_LPAR) begin
                     if (path_count_ff >= PATH_LIMIT) begin
                        ovf_err = 1'b1;
                     end else begin
                        path_count_in   = path_count_ff + 1'b1;
                        point_count_in  = '0;
                        state_in        = S_IN_PATH;
                        rec_valid       = 1'b1;
                        rec.record_kind = gotp_pkg::RK_PATH;
                        rec.glyph_code  = current_code_ff;
                        rec.path_index  = path_count_ff;
                     end
                  end else if (token.token_kind == gotp_pkg::TK_GREATER) begin
                     state_in = S_ADV_GT;
                  end else begin
                     syn_err = 1'b1;
                  end
               end
               S_IN_PATH: begin
                  if (token.token_kind == gotp_pkg::TK_NUMBER) begin
                     held_x_in = token.number_value;
                     state_in  = S_PT_X;
                  end else if (token.token_kind == gotp_pkg::TK_RPAR) begin
                     state_in = S_BODY;
                  end else begin
                     syn_err = 1'b1;
                  end
               end
               S_PT_X: begin
                  if (token.token_kind == gotp_pkg::TK_COLON ||
                      token.token_kind == gotp_pkg::TK_COMMA) begin
                     held_marker_in = (token.token_kind == gotp_pkg::TK_COMMA);
                     state_in       = S_PT_SEP;
                  end else begin
                     syn_err = 1'b1;
                  end
               end
               S_PT_SEP: begin
                  if (token.token_kind != gotp_pkg::TK_NUMBER) begin
                     syn_err = 1'b1;
                  end else if (point_count_ff >= POINT_LIMIT) begin
                     ovf_err = 1'b1;
                  end else begin
                     point_count_in     = point_count_ff + 1'b1;
                     state_in           = S_IN_PATH;
                     rec_valid          = 1'b1;
                     rec.record_kind    = gotp_pkg::RK_POINT;
                     rec.glyph_code     = current_code_ff;
                     rec.path_index     = path_count_ff - 1'b1;
                     rec.point_index    = point_count_ff;
                     rec.coord_x        = held_x_ff;
                     rec.coord_y        = token.number_value;
                     rec.bezier_control = held_marker_ff;
                  end
               end
               S_ADV_GT: begin
                  if (token.token_kind == gotp_pkg::TK_NUMBER) begin
                     held_adv_x_in = token.number_value;
                     state_in      = S_ADV_X;
                  end else begin
                     syn_err = 1'b1;
                  end
               end
               S_ADV_X: begin
                  if (token.token_kind == gotp_pkg::TK_COLON) state_in = S_ADV_SEP;
                  else syn_err = 1'b1;
               end
               S_ADV_SEP: begin
                  if (token.token_kind == gotp_pkg::TK_NUMBER) begin
                     state_in        = S_ADV_Y;
                     rec_valid       = 1'b1;
                     rec.record_kind = gotp_pkg::RK_ADVANCE;
                     rec.glyph_code  = current_code_ff;
                     rec.coord_x     = held_adv_x_ff;
                     rec.coord_y     = token.number_value;
                  end else begin
                     syn_err = 1'b1;
                  end
               end
               S_ADV_Y: begin
                  if (token.token_kind == gotp_pkg::TK_RBRACE) state_in = S_IDLE;
                  else syn_err = 1'b1;
               end
               default: syn_err = 1'b1;
            endcase
         end
         if (syn_err || ovf_err) begin
            halted_in       = 1'b1;
            rec_valid       = 1'b1;
            rec             = '0;
            rec.record_kind = ovf_err ? gotp_pkg::RK_OVERFLOW : gotp_pkg::RK_SYNTAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         held_x_ff       <= '0;
         held_marker_ff  <= 1'b0;
         current_code_ff <= '0;
         path_count_ff   <= '0;
         point_count_ff  <= '0;
         held_adv_x_ff   <= '0;
         halted_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         held_x_ff       <= held_x_in;
         held_marker_ff  <= held_marker_in;
         current_code_ff <= current_code_in;
         path_count_ff   <= path_count_in;
         point_count_ff  <= point_count_in;
         held_adv_x_ff   <= held_adv_x_in;
         halted_ff       <= halted_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) halted_ff |-> !rec_valid)
      else $error("record produced while halted");

   assert property (@(posedge clock) disable iff (reset)
      rec_valid && (rec.record_kind == gotp_pkg::RK_SYNTAX ||
                    rec.record_kind == gotp_pkg::RK_OVERFLOW) |=> halted_ff)
      else $error("error record without halt");

   assert property (@(posedge clock) disable iff (reset)
      path_count_ff <= PATH_LIMIT && point_count_ff <= POINT_LIMIT)
      else $error("path or point count beyond limit");

endmodule

// File: sv/glyph_outline_token_parser.sv
// Top level: input register, grammar parser and record output register.
// A token is held in the input register, and its record is registered in the record output
// register and presented on rsp_chan from there.
// Throughput: one token per cycle while rsp_chan keeps up; with both registers full,
// a stall on rsp_chan holds req_chan.ready low in the same cycle.
// Tokens that yield no record still take one pass through the parser.
// Reset (synchronous, active high) empties both registers, clears counters and halt,
// and returns the grammar to idle.
module glyph_outline_token_parser #(
   parameter int MAX_PATHS   = gotp_pkg::MAX_PATHS_DEFAULT,
   parameter int MAX_POINTS  = gotp_pkg::MAX_POINTS_DEFAULT,
   parameter int GLYPH_SLOTS = gotp_pkg::GLYPH_SLOTS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   gotp_req_if.sink    req_chan,
   gotp_rsp_if.source  rsp_chan
);

   logic                  in_valid_ff;
   gotp_pkg::token_type   in_item_ff;
   logic                  out_valid_ff;
   gotp_pkg::record_type  out_item_ff;
   logic                  advance;
   logic                  rec_valid;
   gotp_pkg::record_type  rec;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.token_kind   <= req_chan.token_kind;
         in_item_ff.code_value   <= req_chan.code_value;
         in_item_ff.number_value <= req_chan.number_value;
      end
   end

   gotp_parser #(
      .MAX_PATHS   (MAX_PATHS),
      .MAX_POINTS  (MAX_POINTS),
      .GLYPH_SLOTS (GLYPH_SLOTS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .token     (in_item_ff),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rec_valid;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rec_valid) begin
         out_item_ff <= rec;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.record_kind    = out_item_ff.record_kind;
   assign rsp_chan.glyph_code     = out_item_ff.glyph_code;
   assign rsp_chan.path_index     = out_item_ff.path_index;
   assign rsp_chan.point_index    = out_item_ff.point_index;
   assign rsp_chan.coord_x        = out_item_ff.coord_x;
   assign rsp_chan.coord_y        = out_item_ff.coord_y;
   assign rsp_chan.bezier_control = out_item_ff.bezier_control;

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending token overwritten");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_item_ff))
      else $error("pending record lost");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_item_ff.record_kind <= gotp_pkg::RK_SUCCESS)
      else $error("record kind out of range");

endmodule

// File: tb/sv/outline_checker.sv
// Checker: predicts glyph outline records from accepted tokens and compares them with the output.
module outline_checker #(
   parameter int MAX_PATHS   = gotp_pkg::MAX_PATHS_DEFAULT,
   parameter int MAX_POINTS  = gotp_pkg::MAX_POINTS_DEFAULT,
   parameter int GLYPH_SLOTS = gotp_pkg::GLYPH_SLOTS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   gotp_req_if  req,
   gotp_rsp_if  rsp,
   output int   failures,
   output int   pending,
   output logic parser_halted,
   output int   tokens_seen,
   output int   records_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import gotp_pkg::*;

   typedef enum logic [3:0] {
      G_IDLE, G_CODE_SEEN, G_EQ_SEEN, G_BODY, G_PATH, G_X_HELD, G_SEP_HELD,
      G_ADV_OPEN, G_ADV_X, G_ADV_SEP, G_ADV_DONE
   } grammar_e;

   grammar_e                  gstate = G_IDLE;
   logic [CODE_W-1:0]         cur_code;
   logic [IDX_W-1:0]          n_paths;
   logic [IDX_W-1:0]          n_points;
   logic signed [COORD_W-1:0] held_x;
   logic signed [COORD_W-1:0] held_adv_x;
   logic                      held_comma;
   record_type                records_due[$];

   initial begin
      failures        = 0;
      pending         = 0;
      parser_halted   = 1'b0;
      tokens_seen     = 0;
      records_checked = 0;
   end

   function automatic bit parse_token(input token_type tok, output record_type rec);
      bit ok;
      bit ovf;
      bit emit;
      rec  = '0;
      ok   = 1'b1;
      ovf  = 1'b0;
      emit = 1'b0;
      if (parser_halted) return 1'b0;
      if (tok.token_kind == TK_END) begin
         if (gstate == G_IDLE) begin
            rec.record_kind = RK_SUCCESS;
            return 1'b1;
         end
         ok = 1'b0;
      end else begin
         case (gstate)
            G_IDLE: begin
               if (tok.token_kind != TK_CODE) ok = 1'b0;
               else if (int'(tok.code_value) >= GLYPH_SLOTS) ovf = 1'b1;
               else begin
                  cur_code        = tok.code_value;
                  n_paths         = '0;
                  n_points        = '0;
                  gstate          = G_CODE_SEEN;
                  rec.record_kind = RK_GLYPH;
                  rec.glyph_code  = cur_code;
                  emit            = 1'b1;
               end
            end
            G_CODE_SEEN: begin
               if (tok.token_kind == TK_EQUALS) gstate = G_EQ_SEEN;
               else ok = 1'b0;
            end
            G_EQ_SEEN: begin
               if (tok.token_kind == TK_LBRACE) gstate = G_BODY;
               else ok = 1'b0;
            end
            G_BODY: begin
               if (tok.token_kind == TK_LPAR) begin
                  if (int'(n_paths) >= MAX_PATHS) ovf = 1'b1;
                  else begin
                     rec.record_kind = RK_PATH;
                     rec.glyph_code  = cur_code;
                     rec.path_index  = n_paths;
                     n_paths         = n_paths + 1'b1;
                     n_points        = '0;
                     gstate          = G_PATH;
                     emit            = 1'b1;
                  end
               end else if (tok.token_kind == TK_GREATER) gstate = G_ADV_OPEN;
               else ok = 1'b0;
            end
            G_PATH: begin
               if (tok.token_kind == TK_NUMBER) begin
                  held_x = tok.number_value;
                  gstate = G_X_HELD;
               end else if (tok.token_kind == TK_RPAR) gstate = G_BODY;
               else ok = 1'b0;
            end
            G_X_HELD: begin
               if (tok.token_kind == TK_COLON || tok.token_kind == TK_COMMA) begin
                  held_comma = (tok.token_kind == TK_COMMA);
                  gstate     = G_SEP_HELD;
               end else ok = 1'b0;
            end
            G_SEP_HELD: begin
               if (tok.token_kind != TK_NUMBER) ok = 1'b0;
               else if (int'(n_points) >= MAX_POINTS) ovf = 1'b1;
               else begin
                  rec.record_kind    = RK_POINT;
                  rec.glyph_code     = cur_code;
                  rec.path_index     = n_paths - 1'b1;
                  rec.point_index    = n_points;
                  rec.coord_x        = held_x;
                  rec.coord_y        = tok.number_value;
                  rec.bezier_control = held_comma;
                  n_points           = n_points + 1'b1;
                  gstate             = G_PATH;
                  emit               = 1'b1;
               end
            end
            G_ADV_OPEN: begin
               if (tok.token_kind == TK_NUMBER) begin
                  held_adv_x = tok.number_value;
                  gstate     = G_ADV_X;
               end else ok = 1'b0;
            end
            G_ADV_X: begin
               if (tok.token_kind == TK_COLON) gstate = G_ADV_SEP;
               else ok = 1'b0;
            end
            G_ADV_SEP: begin
               if (tok.token_kind == TK_NUMBER) begin
                  rec.record_kind = RK_ADVANCE;
                  rec.glyph_code  = cur_code;
                  rec.coord_x     = held_adv_x;
                  rec.coord_y     = tok.number_value;
                  gstate          = G_ADV_DONE;
                  emit            = 1'b1;
               end else ok = 1'b0;
            end
            G_ADV_DONE: begin
               if (tok.token_kind == TK_RBRACE) gstate = G_IDLE;
               else ok = 1'b0;
            end
            default: ok = 1'b0;
         endcase
      end
      if (ovf || !ok) begin
         parser_halted   = 1'b1;
         rec             = '0;
         rec.record_kind = ovf ? RK_OVERFLOW : RK_SYNTAX;
         return 1'b1;
      end
      return emit;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      token_type  tok;
      record_type want;
      if (reset) begin
         gstate        = G_IDLE;
         cur_code      = '0;
         n_paths       = '0;
         n_points      = '0;
         held_x        = '0;
         held_adv_x    = '0;
         held_comma    = 1'b0;
         parser_halted = 1'b0;
         records_due.delete();
      end else begin
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            tok.token_kind   = req.token_kind;
            tok.code_value   = req.code_value;
            tok.number_value = req.number_value;
            tokens_seen++;
            if (parse_token(tok, want)) records_due.push_back(want);
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (records_due.size() == 0) begin
               $error("record kind %0d arrived with nothing expected", rsp.record_kind);
               failures++;
            end else begin
               want = records_due.pop_front();
               check_field("record_kind", 32'(want.record_kind), 32'(rsp.record_kind));
               check_field("glyph_code", 32'(want.glyph_code), 32'(rsp.glyph_code));
               check_field("path_index", 32'(want.path_index), 32'(rsp.path_index));
               check_field("point_index", 32'(want.point_index), 32'(rsp.point_index));
               check_field("coord_x", want.coord_x, rsp.coord_x);
               check_field("coord_y", want.coord_y, rsp.coord_y);
               check_field("bezier_control", 32'(want.bezier_control),
                           32'(rsp.bezier_control));
               records_checked++;
            end
         end
      end
      pending = records_due.size();
   end

endmodule

// File: tb/sv/testbench.sv
// Testbench top: drives glyph outline token streams and a stalling receiver, gives the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gotp_pkg::*;

   localparam int TOKEN_TARGET = 1850;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int { FINISH_PATHS, FINISH_POINTS, FINISH_EARLY_END, FINISH_NOISE } finish_e;
   typedef enum int { RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BEAT } rx_style_e;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gotp_req_if req_chan();
   gotp_rsp_if rsp_chan();

   int   failures;
   int   pending;
   logic halted;
   int   tokens_seen;
   int   records_checked;

   token_type plan[$];
   int        sent = 0;
   int        burst_left = 1;
   int        glyphs = 0;
   int        cycles = 0;
   finish_e   ending;

   glyph_outline_token_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   outline_checker outline_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_chan),
      .rsp             (rsp_chan),
      .failures        (failures),
      .pending         (pending),
      .parser_halted   (halted),
      .tokens_seen     (tokens_seen),
      .records_checked (records_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d records outstanding", pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [COORD_W-1:0] pick_number();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic void put_val(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                                   input logic [COORD_W-1:0] num);
      token_type t;
      t.token_kind   = kind;
      t.code_value   = code;
      t.number_value = num;
      plan.push_back(t);
   endfunction

   function automatic void put(input logic [KIND_W-1:0] kind);
      put_val(kind, CODE_W'($urandom_range(0, 65535)), pick_number());
   endfunction

   function automatic void add_glyph(input int paths, input int pts_lo, input int pts_hi);
      put(TK_CODE);
      put(TK_EQUALS);
      put(TK_LBRACE);
      repeat (paths) begin
         put(TK_LPAR);
         repeat ($urandom_range(pts_lo, pts_hi)) begin
            put(TK_NUMBER);
            put($urandom_range(0, 1) ? TK_COMMA : TK_COLON);
            put(TK_NUMBER);
         end
         put(TK_RPAR);
      end
      put(TK_GREATER);
      put(TK_NUMBER);
      put(TK_COLON);
      put(TK_NUMBER);
      put(TK_RBRACE);
   endfunction

   task automatic send_one(input token_type tok);
      int gap;
      req_chan.token_kind   = tok.token_kind;
      req_chan.code_value   = tok.code_value;
      req_chan.number_value = tok.number_value;
      req_chan.valid        = 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 160);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
         end
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_plan();
      while (plan.size() > 0) send_one(plan.pop_front());
   endtask

   task automatic wait_for_drain();
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin : receiver
      int        k;
      rx_style_e style;
      k     = 0;
      style = RX_OPEN;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         k++;
         if (k == 900 || k == 4000) begin
            rsp_chan.ready = 1'b0;
            repeat (150) @(negedge clock);
         end
         if (k % 200 == 0) style = rx_style_e'($urandom_range(0, 3));
         case (style)
            RX_OPEN:   rsp_chan.ready = 1'b1;
            RX_MOSTLY: rsp_chan.ready = ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_chan.ready = ($urandom_range(0, 3) == 0);
            default:   rsp_chan.ready = k[2];
         endcase
      end
   end

   initial begin : stimulus
      int cut;
      int paths;
      req_chan.valid        = 1'b0;
      req_chan.token_kind   = '0;
      req_chan.code_value   = '0;
      req_chan.number_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // end of input while idle, then glyphs at the code and coordinate extremes
      put(TK_END);
      put_val(TK_CODE, 16'h0000, pick_number());
      put(TK_EQUALS);
      put(TK_LBRACE);
      put(TK_LPAR);
      put_val(TK_NUMBER, CODE_W'($urandom), 32'h8000_0000);
      put(TK_COLON);
      put_val(TK_NUMBER, CODE_W'($urandom), 32'h7FFF_FFFF);
      put_val(TK_NUMBER, CODE_W'($urandom), 32'h0000_0000);
      put(TK_COMMA);
      put_val(TK_NUMBER, CODE_W'($urandom), 32'hFFFF_FFFF);
      put(TK_RPAR);
      put(TK_LPAR);
      put(TK_RPAR);
      put(TK_GREATER);
      put_val(TK_NUMBER, CODE_W'($urandom), 32'h7FFF_FFFF);
      put(TK_COLON);
      put_val(TK_NUMBER, CODE_W'($urandom), 32'h8000_0000);
      put(TK_RBRACE);
      put_val(TK_CODE, 16'hFFFF, pick_number());
      put(TK_EQUALS);
      put(TK_LBRACE);
      put(TK_GREATER);
      put(TK_NUMBER);
      put(TK_COLON);
      put(TK_NUMBER);
      put(TK_RBRACE);
      put(TK_END);
      send_plan();

      while (sent < TOKEN_TARGET - 150) begin
         paths = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
         add_glyph(paths, 0, 6);
         if ($urandom_range(0, 3) == 0) put(TK_END);
         if (glyphs == 10) add_glyph(MAX_PATHS_DEFAULT, 0, 1);
         if (glyphs == 12) add_glyph(1, MAX_POINTS_DEFAULT, MAX_POINTS_DEFAULT);
         send_plan();
         glyphs++;
         if (glyphs == 30) wait_for_drain();
      end
      wait_for_drain();

      // one fault per run, since only a reset clears it
      ending = finish_e'($urandom_range(0, 3));
      case (ending)
         FINISH_PATHS: begin
            put(TK_CODE);
            put(TK_EQUALS);
            put(TK_LBRACE);
            repeat (MAX_PATHS_DEFAULT) begin
               put(TK_LPAR);
               put(TK_RPAR);
            end
            put(TK_LPAR);
         end
         FINISH_POINTS: begin
            put(TK_CODE);
            put(TK_EQUALS);
            put(TK_LBRACE);
            put(TK_LPAR);
            repeat (MAX_POINTS_DEFAULT + 1) begin
               put(TK_NUMBER);
               put($urandom_range(0, 1) ? TK_COMMA : TK_COLON);
               put(TK_NUMBER);
            end
         end
         FINISH_EARLY_END: begin
            add_glyph($urandom_range(0, 3), 0, 3);
            cut = $urandom_range(1, plan.size() - 1);
            while (plan.size() > cut) plan.delete(plan.size() - 1);
            put(TK_END);
         end
         default: begin
            add_glyph($urandom_range(0, 3), 0, 3);
            cut = $urandom_range(0, plan.size() - 1);
            while (plan.size() > cut) plan.delete(plan.size() - 1);
         end
      endcase
      send_plan();
      cut = 0;
      while (!halted && cut < 200) begin
         put_val(KIND_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 65535)),
                 pick_number());
         send_plan();
         cut++;
      end
      // tokens after the fault must be dropped
      repeat (16) put_val(KIND_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 65535)),
                          pick_number());
      send_plan();

      wait_for_drain();
      repeat (16) @(negedge clock);

      $display("Covered %0d tokens over %0d random glyphs, %0d records checked, ending %s",
               tokens_seen, glyphs, records_checked, ending.name());
      $display("Included a glyph at the path limit and a path at the point limit");
      if (pending != 0) $error("%0d expected records never arrived", pending);
      if (failures == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
